// ----- sv/hvpsi_pkg.sv -----
// ----------------------------------------------------------------------------
// hvpsi_pkg
// Types and constants shared by the HV precharge and safety interlock.
// ----------------------------------------------------------------------------
`default_nettype none

package hvpsi_pkg;

	localparam int unsigned FAULT_W = 14;
	localparam int unsigned CFG_W   = 48;
	localparam int unsigned CIDX_W  = 3;

	// fault flag bit positions
	localparam int unsigned F_OVHV   = 0;
	localparam int unsigned F_UVHV   = 1;
	localparam int unsigned F_OCHV   = 2;
	localparam int unsigned F_OV12   = 3;
	localparam int unsigned F_UV12   = 4;
	localparam int unsigned F_OC12   = 5;
	localparam int unsigned F_EFUSE  = 6;
	localparam int unsigned F_OV5    = 7;
	localparam int unsigned F_UV5    = 8;
	localparam int unsigned F_OC5    = 9;
	localparam int unsigned F_TEMP   = 10;
	localparam int unsigned F_PRECHG = 11;
	localparam int unsigned F_COMM   = 12;
	localparam int unsigned F_TILE   = 13;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] CFG_HV_LIMITS   = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_RAIL12      = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_RAIL5       = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_OVERTEMP    = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_WINDOW      = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_TIMEOUT     = 3'd5;

	localparam logic signed [15:0] OVERTEMP_RST = 16'sd100;
	localparam logic [7:0]         WINDOW_RST   = 8'd25;
	localparam logic [31:0]        TIMEOUT_RST  = 32'd1000;

	// pass modes
	localparam logic [1:0] MODE_PLAIN = 2'd0;
	localparam logic [1:0] MODE_ARM   = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// host replies
	localparam logic [1:0] REPLY_NONE = 2'd0;
	localparam logic [1:0] REPLY_ARMED = 2'd1;
	localparam logic [1:0] REPLY_PRECHG_FAIL = 2'd2;

	// indicator colours, bit2 red, bit1 green, bit0 blue
	localparam logic [2:0] LED_BLUE   = 3'd1;
	localparam logic [2:0] LED_GREEN  = 3'd2;
	localparam logic [2:0] LED_CYAN   = 3'd3;
	localparam logic [2:0] LED_RED    = 3'd4;
	localparam logic [2:0] LED_YELLOW = 3'd6;

	typedef struct packed {
		logic [15:0]        hv_out_mv;
		logic [15:0]        hv_in_mv;
		logic [15:0]        r12_out_mv;
		logic [15:0]        r12_in_mv;
		logic [15:0]        r12_ma;
		logic [15:0]        r5_mv;
		logic [15:0]        r5_ma;
		logic signed [15:0] chip_temp;
		logic [4:0]         pin_bits;
		logic [2:0]         link_bits;
		logic [1:0]         mode;
		logic [31:0]        time_ms;
	} meas_t;

	typedef struct packed {
		logic               relay_on;
		logic               precharge_on;
		logic               no_fault;
		logic               fault_shutdown;
		logic [FAULT_W-1:0] fault_flags;
		logic [2:0]         led_rgb;
		logic [1:0]         host_reply;
		logic               faults_cleared;
		logic               hv_requested;
	} status_t;

endpackage

`default_nettype wire

// ----- sv/hvpsi_if.sv -----
// ----------------------------------------------------------------------------
// hvpsi_if
// Valid/ready channels for measurement passes and status results.
// ----------------------------------------------------------------------------
`default_nettype none

interface hvpsi_meas_if;
	logic              valid;
	logic              ready;
	hvpsi_pkg::meas_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface hvpsi_status_if;
	logic                valid;
	logic                ready;
	hvpsi_pkg::status_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/hv_precharge_safety_interlock.sv -----
// ----------------------------------------------------------------------------
// hv_precharge_safety_interlock
// Fault latching, button and host arm handling, precharge sequencing.
// ----------------------------------------------------------------------------
// Pipeline: an accepted pass goes through the input register, then the result
//   register written by the combinational interlock update, to its status beat.
// Throughput: one pass per cycle; the input stage advances whenever the
//   result register is empty or being drained.
// Reset: arst_n clears all interlock state and sets the thresholds to their
//   power-on values (overtemp 100, window 25, timeout 1000 ms, others 0).
`default_nettype none

module hv_precharge_safety_interlock (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	hvpsi_meas_if.sink                        meas,
	hvpsi_status_if.source                    status,
	input  wire logic                         cfg_we,
	input  wire logic [hvpsi_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [hvpsi_pkg::CFG_W-1:0]  cfg_data
);

	// configuration
	logic [31:0]        hv_limits_q;
	logic [47:0]        rail12_q;
	logic [47:0]        rail5_q;
	logic signed [15:0] overtemp_q;
	logic [7:0]         window_q;
	logic [31:0]        timeout_q;

	// interlock state
	logic                          hv_request_q;
	logic                          host_armed_q;
	logic                          prechg_done_q;
	logic                          relay_q;
	logic                          prechg_state_q;
	logic                          button_prev_q;
	logic                          clear_pend_q;
	logic                          shutdown_q;
	logic [hvpsi_pkg::FAULT_W-1:0] fault_q;
	logic [31:0]                   prechg_start_q;

	// pipeline
	logic               valid_s1;
	hvpsi_pkg::meas_t   meas_s1;
	logic               valid_s2;
	hvpsi_pkg::status_t res_s2;
	logic               advance;

	assign advance     = !valid_s2 || status.ready;
	assign meas.ready  = !valid_s1 || advance;
	assign status.valid = valid_s2;
	assign status.data  = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_limits_q <= '0;
			rail12_q    <= '0;
			rail5_q     <= '0;
			overtemp_q  <= hvpsi_pkg::OVERTEMP_RST;
			window_q    <= hvpsi_pkg::WINDOW_RST;
			timeout_q   <= hvpsi_pkg::TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hvpsi_pkg::CFG_HV_LIMITS: hv_limits_q <= cfg_data[31:0];
				hvpsi_pkg::CFG_RAIL12:    rail12_q    <= cfg_data[47:0];
				hvpsi_pkg::CFG_RAIL5:     rail5_q     <= cfg_data[47:0];
				hvpsi_pkg::CFG_OVERTEMP:  overtemp_q  <= $signed(cfg_data[15:0]);
				hvpsi_pkg::CFG_WINDOW:    window_q    <= cfg_data[7:0];
				hvpsi_pkg::CFG_TIMEOUT:   timeout_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// combinational pass update
	logic                          hr0, ha0, cp0, sl1, btn, btn_edge;
	logic                          hr1, hr2, hr_n, ha_n, done_n, relay_n, ps_n, sl_n;
	logic                          cp_n, in_window, timed_out;
	logic [31:0]                   start_n, elapsed;
	logic [hvpsi_pkg::FAULT_W-1:0] f_chk, f_n;
	logic [1:0]                    reply;
	logic [2:0]                    led;
	logic [23:0]                   o_scaled;
	logic [8:0]                    lo_mul, hi_mul;
	logic [24:0]                   lo_lim, hi_lim;
	logic [15:0]                   hv_ov, hv_uv, ov12, uv12, oc12, ov5, uv5, oc5;
	hvpsi_pkg::status_t            res_n;

	assign hv_ov = hv_limits_q[31:16];
	assign hv_uv = hv_limits_q[15:0];
	assign ov12  = rail12_q[47:32];
	assign uv12  = rail12_q[31:16];
	assign oc12  = rail12_q[15:0];
	assign ov5   = rail5_q[47:32];
	assign uv5   = rail5_q[31:16];
	assign oc5   = rail5_q[15:0];

	assign o_scaled = {meas_s1.hv_out_mv, 8'd0};
	assign lo_mul   = 9'd256 - {1'b0, window_q};
	assign hi_mul   = 9'd256 + {1'b0, window_q};
	assign lo_lim   = 25'(meas_s1.hv_in_mv) * 25'(lo_mul);
	assign hi_lim   = 25'(meas_s1.hv_in_mv) * 25'(hi_mul);
	assign in_window = ({1'b0, o_scaled} > lo_lim) && ({1'b0, o_scaled} < hi_lim);

	always_comb begin
		f_chk = '0;
		f_chk[hvpsi_pkg::F_OVHV]  = meas_s1.hv_out_mv > hv_ov || meas_s1.hv_in_mv > hv_ov
			|| !meas_s1.pin_bits[0];
		f_chk[hvpsi_pkg::F_UVHV]  = meas_s1.hv_out_mv < hv_uv || meas_s1.hv_in_mv < hv_uv;
		f_chk[hvpsi_pkg::F_OCHV]  = !meas_s1.pin_bits[1];
		f_chk[hvpsi_pkg::F_OV12]  = meas_s1.r12_out_mv > ov12 || meas_s1.r12_in_mv > ov12;
		f_chk[hvpsi_pkg::F_UV12]  = meas_s1.r12_out_mv < uv12 || meas_s1.r12_in_mv < uv12;
		f_chk[hvpsi_pkg::F_OC12]  = meas_s1.r12_ma > oc12;
		f_chk[hvpsi_pkg::F_EFUSE] = !meas_s1.pin_bits[2];
		f_chk[hvpsi_pkg::F_OV5]   = meas_s1.r5_mv > ov5;
		f_chk[hvpsi_pkg::F_UV5]   = meas_s1.r5_mv < uv5;
		f_chk[hvpsi_pkg::F_OC5]   = meas_s1.r5_ma > oc5;
		f_chk[hvpsi_pkg::F_TEMP]  = meas_s1.chip_temp > overtemp_q;
	end

	always_comb begin
		hr0 = hv_request_q || (meas_s1.mode == hvpsi_pkg::MODE_ARM);
		ha0 = host_armed_q || (meas_s1.mode == hvpsi_pkg::MODE_ARM);
		cp0 = clear_pend_q || (meas_s1.mode == hvpsi_pkg::MODE_CLEAR);
		// a pending clear drops the latch; unlatched flags start from scratch
		sl1 = cp0 ? 1'b0 : shutdown_q;
		f_n = (sl1 ? fault_q : '0) | f_chk;

		btn      = meas_s1.pin_bits[3] || meas_s1.pin_bits[4];
		btn_edge = btn && !button_prev_q;
		cp_n     = btn_edge && (f_n != '0);
		hr1      = (btn_edge && (f_n == '0)) ? !hr0 : hr0;
		hr2      = hr1 && !(ha0 && !meas_s1.link_bits[0]);

		start_n = (hr2 && !prechg_state_q) ? meas_s1.time_ms : prechg_start_q;
		elapsed = meas_s1.time_ms - start_n;
		timed_out = elapsed > timeout_q;

		reply   = hvpsi_pkg::REPLY_NONE;
		ps_n    = hr2;
		done_n  = prechg_done_q;
		relay_n = relay_q;
		ha_n    = ha0;
		if (hr2) begin
			done_n = prechg_done_q || in_window;
			if (done_n) begin
				if (!relay_q && ha0)
					reply = hvpsi_pkg::REPLY_ARMED;
				relay_n = 1'b1;
			end else if (timed_out) begin
				f_n[hvpsi_pkg::F_PRECHG] = 1'b1;
				if (ha0)
					reply = hvpsi_pkg::REPLY_PRECHG_FAIL;
			end
		end else begin
			relay_n = 1'b0;
			done_n  = 1'b0;
			ha_n    = 1'b0;
		end

		if (meas_s1.link_bits[1] && hr2)
			f_n[hvpsi_pkg::F_COMM] = 1'b1;
		if (meas_s1.link_bits[2])
			f_n[hvpsi_pkg::F_TILE] = 1'b1;

		hr_n = hr2;
		sl_n = sl1;
		// any fault while requested: drop HV and keep the flags
		if ((f_n != '0) && hr2) begin
			hr_n    = 1'b0;
			sl_n    = 1'b1;
			relay_n = 1'b0;
			ps_n    = 1'b0;
		end

		priority if (relay_n)
			led = hvpsi_pkg::LED_BLUE;
		else if (hr_n && !done_n)
			led = hvpsi_pkg::LED_CYAN;
		else if (f_n == '0)
			led = hvpsi_pkg::LED_GREEN;
		else if (sl_n)
			led = hvpsi_pkg::LED_RED;
		else if ((f_n & ~(hvpsi_pkg::FAULT_W'(1) << hvpsi_pkg::F_UV5
				| hvpsi_pkg::FAULT_W'(1) << hvpsi_pkg::F_UV12
				| hvpsi_pkg::FAULT_W'(1) << hvpsi_pkg::F_EFUSE)) != '0)
			led = hvpsi_pkg::LED_RED;
		else if (f_n[hvpsi_pkg::F_UV5] && f_n[hvpsi_pkg::F_UV12])
			led = hvpsi_pkg::LED_YELLOW;
		else
			led = hvpsi_pkg::LED_RED;

		res_n.relay_on       = relay_n;
		res_n.precharge_on   = ps_n;
		res_n.no_fault       = (f_n == '0);
		res_n.fault_shutdown = sl_n;
		res_n.fault_flags    = f_n;
		res_n.led_rgb        = led;
		res_n.host_reply     = reply;
		res_n.faults_cleared = cp0;
		res_n.hv_requested   = hr_n;
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (meas.ready) begin
			valid_s1 <= meas.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (meas.valid && meas.ready)
			meas_s1 <= meas.data;
	end

	// result register and state commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			hv_request_q   <= 1'b0;
			host_armed_q   <= 1'b0;
			prechg_done_q  <= 1'b0;
			relay_q        <= 1'b0;
			prechg_state_q <= 1'b0;
			button_prev_q  <= 1'b0;
			clear_pend_q   <= 1'b0;
			shutdown_q     <= 1'b0;
			fault_q        <= '0;
			prechg_start_q <= '0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				hv_request_q   <= hr_n;
				host_armed_q   <= ha_n;
				prechg_done_q  <= done_n;
				relay_q        <= relay_n;
				prechg_state_q <= ps_n;
				button_prev_q  <= btn;
				clear_pend_q   <= cp_n;
				shutdown_q     <= sl_n;
				fault_q        <= f_n;
				prechg_start_q <= start_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1)
			res_s2 <= res_n;
	end

endmodule

`default_nettype wire

// ----- sv/hvpsi_checker.sv -----
// ----------------------------------------------------------------------------
// hvpsi_checker
// Port-level checks on the interlock status beats.
// ----------------------------------------------------------------------------
`default_nettype none

module hvpsi_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               res_valid,
	input wire logic               res_ready,
	input wire hvpsi_pkg::status_t res
);

	a_ready_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.no_fault == (res.fault_flags == '0))
		else $error("no_fault disagrees with fault flags");

	a_relay_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.relay_on |->
			res.hv_requested && res.no_fault && (res.led_rgb == hvpsi_pkg::LED_BLUE))
		else $error("relay closed without a clean HV request");

	a_shutdown_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.fault_shutdown |->
			!res.relay_on && !res.precharge_on && !res.hv_requested)
		else $error("drive left on after fault shutdown");

	a_beat_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("stalled status beat changed");

endmodule

bind hv_precharge_safety_interlock hvpsi_checker u_hvpsi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (status.valid),
	.res_ready (status.ready),
	.res       (status.data)
);

`default_nettype wire
